// File: design/lla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg: shared types and functions of the life-like automaton row step
// Row width, register codes, queue entry and the per-row rule function.
// ----------------------------------------------------------------------------
package lla_pkg;

  localparam int ROW_BITS   = 64;
  localparam int WIDTH_BITS = 7;
  localparam int RULE_BITS  = 9;
  localparam int CFG_ABITS  = 4;
  localparam int CFG_DBITS  = 32;

  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [RULE_BITS-1:0]  rule_t;
  typedef logic [WIDTH_BITS-1:0] width_t;

  typedef enum logic [1:0] {
    REG_ROW_WIDTH    = 2'd0,
    REG_BIRTH_MASK   = 2'd1,
    REG_SURVIVE_MASK = 2'd2
  } reg_idx_t;

  typedef struct packed {
    row_t  row_mask;
    rule_t birth;
    rule_t survive;
  } cfg_t;

  // dual: two results (held row, then the final row); done: frame_done of
  // a single result
  typedef struct packed {
    row_t top;
    row_t mid;
    row_t bot;
    logic dual;
    logic done;
  } task_t;

  function automatic row_t evolve(input row_t top, input row_t mid, input row_t bot,
                                  input row_t row_mask, input rule_t birth,
                                  input rule_t survive);
    logic [ROW_BITS+1:0] t_x;
    logic [ROW_BITS+1:0] m_x;
    logic [ROW_BITS+1:0] b_x;
    logic [3:0]          n;
    rule_t               rule;
    row_t                res;
    t_x = {1'b0, top & row_mask, 1'b0};
    m_x = {1'b0, mid & row_mask, 1'b0};
    b_x = {1'b0, bot & row_mask, 1'b0};
    res = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      n = 4'(t_x[i]) + 4'(t_x[i+1]) + 4'(t_x[i+2])
        + 4'(m_x[i]) + 4'(m_x[i+2])
        + 4'(b_x[i]) + 4'(b_x[i+1]) + 4'(b_x[i+2]);
      rule = m_x[i+1] ? survive : birth;
      res[i] = (n <= 4'd8) ? rule[n] : 1'b0;
    end
    return res & row_mask;
  endfunction

endpackage

// File: design/lla_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_ifs: stream channels of the life-like automaton row step
// Input rows and next-generation result rows, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lla_in_if;
  logic          valid;
  logic          ready;
  lla_pkg::row_t row_cells;
  logic          last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lla_out_if;
  logic          valid;
  logic          ready;
  lla_pkg::row_t next_row;
  logic          frame_done;

  modport source (output valid, output next_row, output frame_done, input ready);
  modport sink   (input valid, input next_row, input frame_done, output ready);
endinterface

// File: design/lla_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_cfg: configuration registers
// APB-style register file for row width and the birth and survive masks.
// ----------------------------------------------------------------------------
module lla_cfg #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lla_pkg::CFG_ABITS-1:0]    paddr,
  input  logic [lla_pkg::CFG_DBITS-1:0]    pwdata,
  output logic [lla_pkg::CFG_DBITS-1:0]    prdata,
  output logic                             pready,
  output lla_pkg::cfg_t                    cfg
);

  lla_pkg::width_t   width_r;
  lla_pkg::rule_t    birth_r;
  lla_pkg::rule_t    survive_r;
  lla_pkg::width_t   used_w;
  lla_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = lla_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= lla_pkg::width_t'(64);
      birth_r   <= lla_pkg::rule_t'(8);
      survive_r <= lla_pkg::rule_t'(12);
    end else if (wr_en) begin
      case (idx)
        lla_pkg::REG_ROW_WIDTH:    width_r   <= pwdata[lla_pkg::WIDTH_BITS-1:0];
        lla_pkg::REG_BIRTH_MASK:   birth_r   <= pwdata[lla_pkg::RULE_BITS-1:0];
        lla_pkg::REG_SURVIVE_MASK: survive_r <= pwdata[lla_pkg::RULE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      lla_pkg::REG_ROW_WIDTH:    prdata = lla_pkg::CFG_DBITS'(width_r);
      lla_pkg::REG_BIRTH_MASK:   prdata = lla_pkg::CFG_DBITS'(birth_r);
      lla_pkg::REG_SURVIVE_MASK: prdata = lla_pkg::CFG_DBITS'(survive_r);
      default:                   prdata = '0;
    endcase
  end

  // clamp the width into 1..MAX_WIDTH
  always_comb begin
    if (width_r == '0) begin
      used_w = lla_pkg::width_t'(1);
    end else if (width_r > lla_pkg::width_t'(MAX_WIDTH)) begin
      used_w = lla_pkg::width_t'(MAX_WIDTH);
    end else begin
      used_w = width_r;
    end
  end

  always_comb begin
    cfg.birth   = birth_r;
    cfg.survive = survive_r;
    for (int i = 0; i < lla_pkg::ROW_BITS; i++) begin
      cfg.row_mask[i] = (lla_pkg::width_t'(i) < used_w);
    end
  end

endmodule

// File: design/lla_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_front: row intake
// Hold the two previous rows and turn each row after the first, or a lone final row, into a task.
// ----------------------------------------------------------------------------
module lla_front (
  input  logic           clk,
  input  logic           rst_n,
  input  lla_pkg::cfg_t  cfg,
  lla_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           push,
  output lla_pkg::task_t push_task
);

  lla_pkg::row_t upper_r, upper_nxt;
  lla_pkg::row_t middle_r, middle_nxt;
  logic          have_mid_r, have_mid_nxt;
  lla_pkg::row_t cur;
  logic          accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign cur         = in_ch.row_cells & cfg.row_mask;
  assign push        = accept && (have_mid_r || in_ch.last_row);

  always_comb begin
    push_task.top  = have_mid_r ? (upper_r & cfg.row_mask) : '0;
    push_task.mid  = have_mid_r ? (middle_r & cfg.row_mask) : cur;
    push_task.bot  = have_mid_r ? cur : '0;
    push_task.dual = have_mid_r && in_ch.last_row;
    push_task.done = !have_mid_r;
  end

  always_comb begin
    upper_nxt    = upper_r;
    middle_nxt   = middle_r;
    have_mid_nxt = have_mid_r;
    if (accept) begin
      if (in_ch.last_row) begin
        upper_nxt    = '0;
        middle_nxt   = '0;
        have_mid_nxt = 1'b0;
      end else begin
        upper_nxt    = have_mid_r ? (middle_r & cfg.row_mask) : '0;
        middle_nxt   = cur;
        have_mid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r    <= '0;
      middle_r   <= '0;
      have_mid_r <= 1'b0;
    end else begin
      upper_r    <= upper_nxt;
      middle_r   <= middle_nxt;
      have_mid_r <= have_mid_nxt;
    end
  end

endmodule

// File: design/lla_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_queue: task queue
// Two-entry queue between the row intake and the rule evaluation.
// ----------------------------------------------------------------------------
module lla_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lla_pkg::task_t push_task,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lla_pkg::task_t head
);

  lla_pkg::task_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/lla_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_back: rule evaluation
// Apply the birth/survive rule on 64 lanes and register the result row.
// ----------------------------------------------------------------------------
module lla_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lla_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  lla_pkg::task_t head,
  output logic           pop,
  lla_out_if.source      out_ch
);

  logic          phase_r, phase_nxt;
  logic          out_valid_r, out_valid_nxt;
  lla_pkg::row_t next_row_r;
  logic          frame_done_r;
  logic          load;
  logic          emit;
  lla_pkg::row_t a_row, b_row, c_row;
  logic          done;

  assign load = !out_valid_r || out_ch.ready;
  assign emit = load && head_valid;

  always_comb begin
    if (phase_r) begin
      a_row = head.mid;
      b_row = head.bot;
      c_row = '0;
    end else begin
      a_row = head.top;
      b_row = head.mid;
      c_row = head.bot;
    end
    done = head.dual ? phase_r : head.done;
  end

  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = head_valid;
    end
    if (emit) begin
      if (head.dual && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      next_row_r   <= lla_pkg::evolve(a_row, b_row, c_row, cfg.row_mask,
                                      cfg.birth, cfg.survive);
      frame_done_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_row   = next_row_r;
  assign out_ch.frame_done = frame_done_r;

endmodule

// File: design/life_like_automaton_row_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_row_step: one generation of a B/S-rule automaton
// Rows stream in raster order; each row after the first yields the next
// generation of the row above, and the final row also yields its own.
// ----------------------------------------------------------------------------
//  channel   dir   beat payload                 handshake
//  in_ch     in    row_cells[63:0], last_row     valid/ready
//  out_ch    out   next_row[63:0], frame_done    valid/ready
//  cfg_*     in    row_width, birth/survive mask APB-style, pready tied high
//
//  One row per cycle while the task queue is not full; a final row that
//  follows a held row passes the rule stage once per result beat. Input
//  beats pass through the two-entry task queue and the output register.
//  Synchronous active-low reset empties the queue and drops any held row.
//  Input stalls only when the task queue is full; output stalls back up there.
// ----------------------------------------------------------------------------
module life_like_automaton_row_step #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lla_in_if.sink                        in_ch,
  lla_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lla_pkg::CFG_ABITS-1:0] cfg_paddr,
  input  logic [lla_pkg::CFG_DBITS-1:0] cfg_pwdata,
  output logic [lla_pkg::CFG_DBITS-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  lla_pkg::cfg_t  cfg;
  logic           q_full;
  logic           push;
  lla_pkg::task_t push_task;
  logic           pop;
  logic           head_valid;
  lla_pkg::task_t head;

  lla_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lla_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_task (push_task)
  );

  lla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_task  (push_task),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lla_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
